@@ design/slcrc_pkg.sv @@
`timescale 1ns / 1ps
package slcrc_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 512;
    localparam int HEADER_BYTES        = 6;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // configuration register indexes
    localparam logic CFG_FIRST_SYNC  = 1'b0;
    localparam logic CFG_SECOND_SYNC = 1'b1;

    localparam logic [7:0] FIRST_SYNC_RESET  = 8'h5A;
    localparam logic [7:0] SECOND_SYNC_RESET = 8'hA5;

    // header byte positions
    localparam int HDR_LEN_LO = 2;
    localparam int HDR_LEN_HI = 3;
    localparam int HDR_CRC_LO = 4;
    localparam int HDR_CRC_HI = 5;

    // frame status codes
    localparam logic [1:0] STS_GOOD    = 2'd0;
    localparam logic [1:0] STS_CRC_ERR = 2'd1;
    localparam logic [1:0] STS_LEN_ERR = 2'd2;

    typedef struct packed {
        logic [8:0] payload_length;
        logic [1:0] frame_status;
        logic       frame_done;
        logic       payload_valid;
        logic [7:0] payload_byte;
    } t_result;

    // crc-16, poly 0x1021, msb first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/slcrc_parser.sv @@
`timescale 1ns / 1ps
module slcrc_parser
    import slcrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_first_sync,
    input  logic [7:0] i_second_sync,
    output t_result    o_result
);

    localparam int          CW        = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [15:0] LEN_BOUND = 16'(MAX_FRAME_BYTES - HEADER_BYTES);

    logic [7:0]    r_prev,     n_prev;
    logic [15:0]   r_prev_crc, n_prev_crc;
    logic [CW-1:0] r_count,    n_count;
    logic [15:0]   r_len,      n_len;
    logic [15:0]   r_crc,      n_crc;
    logic [15:0]   r_rcrc,     n_rcrc;
    logic [CW-1:0] w_count_inc;
    logic          w_check;

    assign w_count_inc = r_count + 1'b1;

    always_comb begin
        n_prev     = r_prev;
        n_prev_crc = r_prev_crc;
        n_count    = r_count;
        n_len      = r_len;
        n_crc      = r_crc;
        n_rcrc     = r_rcrc;
        w_check    = 1'b0;
        o_result   = '0;
        if (i_accept) begin
            if (r_count == '0) begin
                // hunting: crc of the held byte is kept ready
                n_prev     = i_rx_byte;
                n_prev_crc = crc_byte(16'h0000, i_rx_byte);
                if (r_prev == i_first_sync && i_rx_byte == i_second_sync) begin
                    n_crc   = crc_byte(r_prev_crc, i_rx_byte);
                    n_count = CW'(HDR_LEN_LO);
                end
            end else if (r_count < CW'(HEADER_BYTES)) begin
                unique case (r_count)
                    CW'(HDR_LEN_LO): begin
                        n_len = {8'h00, i_rx_byte};
                        n_crc = crc_byte(r_crc, i_rx_byte);
                    end
                    CW'(HDR_LEN_HI): begin
                        n_len = {i_rx_byte, r_len[7:0]};
                        n_crc = crc_byte(r_crc, i_rx_byte);
                    end
                    CW'(HDR_CRC_LO): begin
                        n_rcrc = {8'h00, i_rx_byte};
                    end
                    default: begin
                        n_rcrc = {i_rx_byte, r_rcrc[7:0]};
                    end
                endcase
                n_count = w_count_inc;
                if (r_count == CW'(HDR_CRC_HI)) begin
                    if (r_len > LEN_BOUND) begin
                        o_result.frame_done   = 1'b1;
                        o_result.frame_status = STS_LEN_ERR;
                        n_count               = '0;
                    end else if (r_len == 16'h0000) begin
                        w_check = 1'b1;
                    end
                end
            end else begin
                o_result.payload_byte  = i_rx_byte;
                o_result.payload_valid = 1'b1;
                n_crc                  = crc_byte(r_crc, i_rx_byte);
                n_count                = w_count_inc;
                if (17'(w_count_inc) >= 17'(r_len) + 17'(HEADER_BYTES)) begin
                    w_check = 1'b1;
                end
            end

            if (w_check) begin
                o_result.frame_done     = 1'b1;
                o_result.frame_status   = (n_crc == n_rcrc) ? STS_GOOD : STS_CRC_ERR;
                o_result.payload_length = r_len[8:0];
                n_count                 = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_prev_crc <= '0;
            r_count    <= '0;
            r_len      <= '0;
            r_crc      <= '0;
            r_rcrc     <= '0;
        end else begin
            r_prev     <= n_prev;
            r_prev_crc <= n_prev_crc;
            r_count    <= n_count;
            r_len      <= n_len;
            r_crc      <= n_crc;
            r_rcrc     <= n_rcrc;
        end
    end

endmodule

@@ design/slcrc_skid.sv @@
`timescale 1ns / 1ps
module slcrc_skid #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_out_valid;
    logic [W-1:0] r_out_data;
    logic         r_skid_valid;
    logic [W-1:0] r_skid_data;
    logic         w_take;
    logic         w_load;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign w_take  = r_out_valid && i_ready;
    assign w_load  = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (!r_out_valid || w_take) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end else if (w_take && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

endmodule

@@ design/sync_length_crc16_frame_receiver.sv @@
`timescale 1ns / 1ps
// the result of an accepted input byte is registered in the output register, or in the skid register during a stall
// throughput: one byte per cycle while the skid register is empty; the crc update and header counter are byte-wide
// a two-entry output stage (output register plus skid register) keeps input flowing
// while the downstream side stalls, until the skid register is full
// reset: synchronous, active low; clears parser state (hunting), sync registers to 0x5A / 0xA5
module sync_length_crc16_frame_receiver
    import slcrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,

    // received byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [9:8] frame_status,
                                        // [18:10] payload_length, [23:19] zero
    output logic        m_axis_tlast,   // frame_done
    output logic        m_axis_tuser    // payload_valid
);

    // sync byte registers; the user must write them only while idle, the block does not enforce it
    logic [7:0] r_first_sync;
    logic [7:0] r_second_sync;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync  <= FIRST_SYNC_RESET;
            r_second_sync <= SECOND_SYNC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_SYNC:  r_first_sync  <= i_cfg_data;
                CFG_SECOND_SYNC: r_second_sync <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a transaction on the input side advances the parser
    logic    w_in_accept;
    t_result w_result;
    t_result w_out;

    assign w_in_accept = s_axis_tvalid && s_axis_tready;

    // sync hunt, header capture, crc and frame end decision
    slcrc_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_accept),
        .i_rx_byte    (s_axis_tdata),
        .i_first_sync (r_first_sync),
        .i_second_sync(r_second_sync),
        .o_result     (w_result)
    );

    // result register with skid slot
    slcrc_skid #(
        .W($bits(t_result))
    ) u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_in_accept),
        .o_ready(s_axis_tready),
        .i_data (w_result),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (w_out)
    );

    // output packing
    assign m_axis_tdata = {5'b00000, w_out.payload_length, w_out.frame_status,
                           w_out.payload_byte};
    assign m_axis_tlast = w_out.frame_done;
    assign m_axis_tuser = w_out.payload_valid;

endmodule

@@ dv/sync_length_crc16_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
module sync_length_crc16_frame_receiver_tb;
    import slcrc_pkg::*;

    localparam int MAX_PAYLOAD  = DEF_MAX_FRAME_BYTES - HEADER_BYTES;
    localparam int STALL_LIMIT  = 2000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 8;

    // tracks the parser state and keeps the outputs it should produce, oldest first
    class frame_parse_tracker;
        logic [7:0]  first_sync;
        logic [7:0]  second_sync;
        logic [7:0]  last_rx;
        int unsigned hdr_pos;       // 0 while hunting for sync
        logic [15:0] len_field;
        logic [15:0] crc_run;
        logic [15:0] crc_rx;
        t_result     frame_outputs_q[$];
        int unsigned errors;

        function new();
            first_sync  = FIRST_SYNC_RESET;
            second_sync = SECOND_SYNC_RESET;
            last_rx     = '0;
            hdr_pos     = 0;
            len_field   = '0;
            crc_run     = '0;
            crc_rx      = '0;
            errors      = 0;
        endfunction

        // bitwise crc-16/xmodem, one input bit at a time
        static function logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            r = c;
            for (int i = 7; i >= 0; i--) begin
                fb = r[15] ^ b[i];
                r  = {r[14:0], 1'b0};
                if (fb) begin
                    r = r ^ 16'h1021;
                end
            end
            return r;
        endfunction

        function void set_sync(input logic idx, input logic [7:0] value);
            if (idx == CFG_FIRST_SYNC) begin
                first_sync = value;
            end else begin
                second_sync = value;
            end
        endfunction

        function int unsigned pending();
            return frame_outputs_q.size();
        endfunction

        // one accepted rx byte gives exactly one output
        function void take_rx_byte(input logic [7:0] b);
            t_result     r;
            logic [7:0]  prev;
            bit          end_of_frame;
            r            = '0;
            end_of_frame = 1'b0;
            if (hdr_pos == 0) begin
                // hunting: two consecutive bytes must match the sync pair
                prev    = last_rx;
                last_rx = b;
                if (prev == first_sync && b == second_sync) begin
                    crc_run = crc_update(crc_update(16'h0000, prev), b);
                    hdr_pos = 2;
                end
            end else if (hdr_pos < HEADER_BYTES) begin
                case (hdr_pos)
                    HDR_LEN_LO: begin
                        len_field = {8'h00, b};
                        crc_run   = crc_update(crc_run, b);
                    end
                    HDR_LEN_HI: begin
                        len_field[15:8] = b;
                        crc_run         = crc_update(crc_run, b);
                    end
                    HDR_CRC_LO: begin
                        crc_rx = {8'h00, b};
                    end
                    default: begin
                        crc_rx[15:8] = b;
                    end
                endcase
                hdr_pos++;
                if (hdr_pos == HEADER_BYTES) begin
                    if (len_field > MAX_PAYLOAD) begin
                        // oversize length rejects the frame right on the last header byte
                        r.frame_done   = 1'b1;
                        r.frame_status = STS_LEN_ERR;
                        hdr_pos        = 0;
                    end else if (len_field == 0) begin
                        end_of_frame = 1'b1;
                    end
                end
            end else begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                crc_run         = crc_update(crc_run, b);
                hdr_pos++;
                if (hdr_pos >= int'(len_field) + HEADER_BYTES) begin
                    end_of_frame = 1'b1;
                end
            end
            if (end_of_frame) begin
                r.frame_done     = 1'b1;
                r.frame_status   = (crc_run == crc_rx) ? STS_GOOD : STS_CRC_ERR;
                r.payload_length = len_field[8:0];
                hdr_pos          = 0;
            end
            frame_outputs_q.push_back(r);
        endfunction

        function void cmp(input string field, input int unsigned want, input int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void match_output(input logic [23:0] data, input logic last, input logic user);
            t_result want;
            if (frame_outputs_q.size() == 0) begin
                $error("output transaction with nothing outstanding: tdata %h", data);
                errors++;
                return;
            end
            want = frame_outputs_q.pop_front();
            cmp("payload_byte", want.payload_byte, data[7:0]);
            cmp("frame_status", want.frame_status, data[9:8]);
            cmp("payload_length", want.payload_length, data[18:10]);
            cmp("tdata_pad", 0, data[23:19]);
            cmp("frame_done", want.frame_done, last);
            cmp("payload_valid", want.payload_valid, user);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_idx     = CFG_FIRST_SYNC;
    logic [7:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;      // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;            // [7:0] payload_byte, [9:8] frame_status,
                                          // [18:10] payload_length, [23:19] zero
    logic        m_axis_tlast;            // frame_done
    logic        m_axis_tuser;            // payload_valid

    frame_parse_tracker tracker = new();

    bit          no_gaps    = 1'b0;   // when set neither side idles
    logic [7:0]  sync_a     = FIRST_SYNC_RESET;
    logic [7:0]  sync_b     = SECOND_SYNC_RESET;
    int unsigned bytes_sent = 0;
    int unsigned stall_cnt  = 0;

    sync_length_crc16_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // downstream backpressure, changed on the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 7);
    end

    // monitors sample both streams on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            tracker.take_rx_byte(s_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.match_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    // watchdog: ends the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // present one byte and hold it until the transaction completes,
    // with an occasional idle cycle in front
    task automatic push_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    // stop sending and let every outstanding output drain
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_sync(input logic idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_sync(idx, value);
        if (idx == CFG_FIRST_SYNC) begin
            sync_a = value;
        end else begin
            sync_b = value;
        end
    endtask

    // full frame with the current sync pair; fill < 0 means random payload,
    // an oversize length sends the header only
    task automatic send_frame(input int unsigned len_field, input bit bad_crc, input int fill);
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [15:0] len16;
        int unsigned n;
        len16 = len_field[15:0];
        n     = (len_field <= MAX_PAYLOAD) ? len_field : 0;
        for (int unsigned i = 0; i < n; i++) begin
            body.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        end
        crc = frame_parse_tracker::crc_update(16'h0000, sync_a);
        crc = frame_parse_tracker::crc_update(crc, sync_b);
        crc = frame_parse_tracker::crc_update(crc, len16[7:0]);
        crc = frame_parse_tracker::crc_update(crc, len16[15:8]);
        foreach (body[i]) begin
            crc = frame_parse_tracker::crc_update(crc, body[i]);
        end
        if (bad_crc) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        push_byte(sync_a);
        push_byte(sync_b);
        push_byte(len16[7:0]);
        push_byte(len16[15:8]);
        push_byte(crc[7:0]);
        push_byte(crc[15:8]);
        foreach (body[i]) begin
            push_byte(body[i]);
        end
    endtask

    // mostly well-formed frames, with bad crcs, oversize lengths,
    // cut-off headers and line noise mixed in
    task automatic run_traffic(input int unsigned budget, input bit with_max_frame);
        int unsigned start;
        int unsigned pick;
        start = bytes_sent;
        if (with_max_frame) begin
            send_frame(MAX_PAYLOAD, 1'b0, -1);
        end
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                // hold the sender until the output side has caught up
                wait_idle();
            end else if (pick < 70) begin
                send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                       : $urandom_range(4, 24), 1'b0, -1);
            end else if (pick < 78) begin
                send_frame($urandom_range(0, 24), 1'b1, -1);
            end else if (pick < 84) begin
                // length just past the bound, or anywhere above it
                send_frame(($urandom_range(0, 2) == 0) ? MAX_PAYLOAD + 1
                                                       : $urandom_range(MAX_PAYLOAD + 1, 65535),
                           1'b0, -1);
            end else if (pick < 90) begin
                // header cut short: whatever follows is parsed as the rest of it
                push_byte(sync_a);
                push_byte(sync_b);
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        // synchronous reset, applied once
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames on the reset sync pair
        send_frame(0, 1'b0, -1);            // empty payload, crc good
        send_frame(1, 1'b0, 8'hFF);         // single all-ones byte
        send_frame(1, 1'b1, 8'h00);         // single zero byte, crc mismatch
        send_frame(16'hFFFF, 1'b0, -1);     // largest length field, rejected
        run_traffic(50, 1'b0);

        // sync extremes, no idling on either side for this stretch
        wait_idle();
        write_sync(CFG_FIRST_SYNC, 8'h00);
        write_sync(CFG_SECOND_SYNC, 8'hFF);
        no_gaps = 1'b1;
        run_traffic(50, 1'b0);
        no_gaps = 1'b0;

        // swapped extremes, one maximum-length frame
        wait_idle();
        write_sync(CFG_FIRST_SYNC, 8'hFF);
        write_sync(CFG_SECOND_SYNC, 8'h00);
        run_traffic(520, 1'b1);

        // equal sync bytes: one matching byte can restart right after a frame
        wait_idle();
        write_sync(CFG_FIRST_SYNC, 8'h3C);
        write_sync(CFG_SECOND_SYNC, 8'h3C);
        run_traffic(50, 1'b0);

        // arbitrary pair
        wait_idle();
        write_sync(CFG_FIRST_SYNC, 8'($urandom_range(0, 255)));
        write_sync(CFG_SECOND_SYNC, 8'($urandom_range(0, 255)));
        run_traffic(50, 1'b0);

        // back to the reset pair
        wait_idle();
        write_sync(CFG_FIRST_SYNC, FIRST_SYNC_RESET);
        write_sync(CFG_SECOND_SYNC, SECOND_SYNC_RESET);
        run_traffic(30, 1'b0);

        // drain and settle
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            $error("%0d outputs never arrived", tracker.pending());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/slcrc_pkg.sv
design/slcrc_parser.sv
design/slcrc_skid.sv
design/sync_length_crc16_frame_receiver.sv
dv/sync_length_crc16_frame_receiver_tb.sv
